// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check an implication that also holds while reset is asserted.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/liu68k_pkg.sv =====
// Package of opcodes, outcome codes and types for the 68000 logical unit.
package liu68k_pkg;

    // Operation codes
    localparam logic [3:0] OP_AND      = 4'd0;
    localparam logic [3:0] OP_ANDI     = 4'd1;
    localparam logic [3:0] OP_ANDI_CCR = 4'd2;
    localparam logic [3:0] OP_ANDI_SR  = 4'd3;
    localparam logic [3:0] OP_OR       = 4'd4;
    localparam logic [3:0] OP_ORI      = 4'd5;
    localparam logic [3:0] OP_ORI_CCR  = 4'd6;
    localparam logic [3:0] OP_ORI_SR   = 4'd7;
    localparam logic [3:0] OP_EOR      = 4'd8;
    localparam logic [3:0] OP_EORI     = 4'd9;
    localparam logic [3:0] OP_EORI_CCR = 4'd10;
    localparam logic [3:0] OP_EORI_SR  = 4'd11;
    localparam logic [3:0] OP_NOT      = 4'd12;

    // Outcome codes
    localparam logic [1:0] OUTCOME_OK   = 2'd0;
    localparam logic [1:0] OUTCOME_BAD  = 2'd1;
    localparam logic [1:0] OUTCOME_PRIV = 2'd2;

    // Size codes from instruction bits 7:6
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_BAD  = 2'd3;

    // Status register layout
    localparam logic [15:0] SR_RESET   = 16'h2700;
    localparam int          SR_SUPER_B = 13;

    // Result of one executed instruction
    typedef struct packed {
        logic [31:0] result_value;
        logic        result_to_register;
        logic [15:0] sr_next;
        logic [4:0]  cycle_count;
        logic [1:0]  outcome;
    } exec_res_t;

endpackage

// ===== design/liu68k_exec.sv =====
// Combinational execute logic for one 68000 logical instruction.
module liu68k_exec (
    input  logic [3:0]              op,
    input  logic [15:0]             instruction_word,
    input  logic [31:0]             source_operand,
    input  logic [31:0]             ea_operand,
    input  logic [15:0]             sr,
    output liu68k_pkg::exec_res_t   res
);
    import liu68k_pkg::*;

    logic [15:0] ext;
    logic [1:0]  size;
    logic        lng;
    logic        dir;
    logic [31:0] mask;
    logic [31:0] raw;
    logic [31:0] masked;
    logic [31:0] base;
    logic        flag_n;
    logic        flag_z;

    assign ext  = source_operand[15:0];
    assign size = instruction_word[7:6];
    assign lng  = (size == SIZE_LONG);
    assign dir  = instruction_word[8];

    // Select the operand mask for the size
    always_comb begin
        case (size)
            SIZE_BYTE: mask = 32'h0000_00FF;
            SIZE_WORD: mask = 32'h0000_FFFF;
            default:   mask = 32'hFFFF_FFFF;
        endcase
    end

    // Form the raw logical result
    always_comb begin
        case (op)
            OP_AND, OP_ANDI: raw = source_operand & ea_operand;
            OP_OR, OP_ORI:   raw = source_operand | ea_operand;
            OP_EOR, OP_EORI: raw = source_operand ^ ea_operand;
            default:         raw = ~ea_operand;
        endcase
    end

    assign masked = raw & mask;
    assign flag_z = (masked == 32'd0);

    always_comb begin
        case (size)
            SIZE_BYTE: flag_n = masked[7];
            SIZE_WORD: flag_n = masked[15];
            default:   flag_n = masked[31];
        endcase
    end

    // Register-destination forms keep the data register's upper bits
    assign base = ((op == OP_AND || op == OP_OR) && !dir) ? source_operand : ea_operand;

    // Decode the operation into result, status, cycle count and outcome
    always_comb begin
        res.result_value       = 32'd0;
        res.result_to_register = 1'b0;
        res.sr_next            = sr;
        res.cycle_count        = 5'd0;
        res.outcome            = OUTCOME_OK;
        case (op)
            OP_ANDI_CCR: begin
                res.sr_next     = sr & (ext | 16'hFF00);
                res.cycle_count = 5'd20;
            end
            OP_ORI_CCR: begin
                res.sr_next     = sr | {8'h00, ext[7:0]};
                res.cycle_count = 5'd20;
            end
            OP_EORI_CCR: begin
                res.sr_next     = sr ^ {8'h00, ext[7:0]};
                res.cycle_count = 5'd20;
            end
            OP_ANDI_SR, OP_ORI_SR, OP_EORI_SR: begin
                if (!sr[SR_SUPER_B]) begin
                    res.outcome = OUTCOME_PRIV;
                end else begin
                    res.cycle_count = 5'd20;
                    case (op)
                        OP_ANDI_SR: res.sr_next = sr & ext;
                        OP_ORI_SR:  res.sr_next = sr | ext;
                        default:    res.sr_next = sr ^ ext;
                    endcase
                end
            end
            OP_AND, OP_OR, OP_ANDI, OP_ORI, OP_EORI, OP_EOR, OP_NOT: begin
                if (size == SIZE_BAD) begin
                    res.outcome = OUTCOME_BAD;
                end else begin
                    res.result_value = (base & ~mask) | masked;
                    res.sr_next      = {sr[15:4], flag_n, flag_z, 2'b00};
                    case (op)
                        OP_AND, OP_OR: begin
                            if (dir) begin
                                res.cycle_count = lng ? 5'd12 : 5'd8;
                            end else begin
                                res.result_to_register = 1'b1;
                                if (lng) begin
                                    res.cycle_count =
                                        (instruction_word[5:4] == 2'b00 ||
                                         instruction_word[5:0] == 6'h3C) ? 5'd8 : 5'd6;
                                end else begin
                                    res.cycle_count = 5'd4;
                                end
                            end
                        end
                        OP_ANDI, OP_ORI, OP_EORI: begin
                            if (instruction_word[5:3] != 3'b000) begin
                                res.cycle_count = lng ? 5'd20 : 5'd12;
                            end else begin
                                res.cycle_count = lng ? 5'd16 : 5'd8;
                            end
                        end
                        OP_EOR: begin
                            if (instruction_word[5:3] != 3'b000) begin
                                res.cycle_count = lng ? 5'd12 : 5'd8;
                            end else begin
                                res.cycle_count = lng ? 5'd8 : 5'd4;
                            end
                        end
                        default: begin
                            if (instruction_word[5:4] != 2'b00) begin
                                res.cycle_count = lng ? 5'd12 : 5'd8;
                            end else begin
                                res.cycle_count = lng ? 5'd6 : 5'd4;
                            end
                        end
                    endcase
                end
            end
            default: begin
                res.outcome = OUTCOME_BAD;
            end
        endcase
    end

endmodule

// ===== design/logical_instruction_unit_68k_top.sv =====
// Throughput: one word per cycle unless the result port stalls; execution is a single pass from the input
// register through the logic unit into the result register, which also updates the status register.
// A stalled result port holds the result register; once the input register also fills, the input stalls.
// Reset (aresetn low, synchronous): both stages empty, status register 0x2700.
// Top level of the 68000 logical instruction unit.
`include "assert_macros.svh"

module logical_instruction_unit_68k_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_op,
    input  logic [15:0] s_instruction_word,
    input  logic [31:0] s_source_operand,
    input  logic [31:0] s_ea_operand,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_value,
    output logic        m_result_to_register,
    output logic [15:0] m_status_register_out,
    output logic [4:0]  m_cycle_count,
    output logic [1:0]  m_outcome
);
    import liu68k_pkg::*;

    logic        in_valid_reg;
    logic [3:0]  op_reg;
    logic [15:0] iw_reg;
    logic [31:0] src_reg;
    logic [31:0] ea_reg;
    logic        out_valid_reg;
    logic [31:0] result_value_reg;
    logic        to_reg_reg;
    logic [15:0] sr_out_reg;
    logic [4:0]  cycle_count_reg;
    logic [1:0]  outcome_reg;
    logic [15:0] sr_reg;
    logic [15:0] sr_next;
    logic        advance;
    exec_res_t   exec_res;

    // Move a word forward when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign sr_next = advance ? exec_res.sr_next : sr_reg;

    liu68k_exec u_exec (
        .op               (op_reg),
        .instruction_word (iw_reg),
        .source_operand   (src_reg),
        .ea_operand       (ea_reg),
        .sr               (sr_reg),
        .res              (exec_res)
    );

    // Track stage occupancy and the status register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sr_reg        <= SR_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            sr_reg <= sr_next;
        end
    end

    // Capture an incoming word
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_op;
            iw_reg  <= s_instruction_word;
            src_reg <= s_source_operand;
            ea_reg  <= s_ea_operand;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_value_reg <= exec_res.result_value;
            to_reg_reg       <= exec_res.result_to_register;
            sr_out_reg       <= exec_res.sr_next;
            cycle_count_reg  <= exec_res.cycle_count;
            outcome_reg      <= exec_res.outcome;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_result_value        = result_value_reg;
    assign m_result_to_register  = to_reg_reg;
    assign m_status_register_out = sr_out_reg;
    assign m_cycle_count         = cycle_count_reg;
    assign m_outcome             = outcome_reg;

    // Hold the status register when no word executes
    `ASSERT_CLK(a_sr_hold, aclk, aresetn, !advance |=> $stable(sr_reg), "status changed while idle")
    // A faulting word leaves the status register unchanged
    `ASSERT_CLK(a_fault_sr, aclk, aresetn, (advance && exec_res.outcome != OUTCOME_OK) |=> $stable(sr_reg), "faulting word changed status")
    // A faulting result carries no cycle count
    `ASSERT_CLK(a_fault_cyc, aclk, aresetn, (m_valid && m_outcome != OUTCOME_OK) |-> (m_cycle_count == 5'd0), "faulting result has cycles")
    // Back-pressure only with a full input register
    `ASSERT_CLK(a_ready_full, aclk, aresetn, !s_ready |-> in_valid_reg, "input stalled while empty")

endmodule
